// File: src/dqu_pkg.sv
// Shared types and constants for the double-ended queue unit.
// Used by dqu_cell and double_ended_queue_unit; depends on nothing else.
`timescale 1ns / 1ps

package dqu_pkg;

  // Width of one stored value.
  localparam int DATA_W = 32;

  // Requested operation of one input item.
  typedef enum logic [1:0] {
    ACT_PUSH_BACK  = 2'd0,
    ACT_PUSH_FRONT = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_t;

  // Result status of one item.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Operation broadcast to all cells of the chain at once.
  typedef enum logic [2:0] {
    CELL_HOLD       = 3'd0,
    CELL_PUSH_FRONT = 3'd1,
    CELL_PUSH_BACK  = 3'd2,
    CELL_POP_FRONT  = 3'd3,
    CELL_POP_BACK   = 3'd4
  } cell_op_t;

  // Command bundle that the controller sends to all cells.
  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0]  value;
  } cell_cmd_t;

endpackage

// File: src/dqu_cell.sv
// One storage cell of the queue chain: a value register and an occupied flag.
// Depends on dqu_pkg for the command type and the data width.
`timescale 1ns / 1ps

module dqu_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dqu_pkg::cell_cmd_t               cmd,
  input  logic signed [dqu_pkg::DATA_W-1:0] left_data,
  input  logic                             left_occ,
  input  logic signed [dqu_pkg::DATA_W-1:0] right_data,
  input  logic                             right_occ,
  output logic signed [dqu_pkg::DATA_W-1:0] data_o,
  output logic                             occ_o,
  output logic signed [dqu_pkg::DATA_W-1:0] back_word
);

  logic signed [dqu_pkg::DATA_W-1:0] data_r, data_nxt;
  logic                              occ_r, occ_nxt;
  logic                              is_last;
  logic                              is_first_free;

  // The queue is packed toward the front, so the back entry is the last
  // occupied cell and the next back slot is the first free one.
  assign is_last       = occ_r && !right_occ;
  assign is_first_free = !occ_r && left_occ;

  // Next contents for the broadcast operation.
  always_comb begin
    data_nxt = data_r;
    occ_nxt  = occ_r;
    case (cmd.op)
      dqu_pkg::CELL_PUSH_FRONT: begin
        data_nxt = left_data;
        occ_nxt  = left_occ;
      end
      dqu_pkg::CELL_POP_FRONT: begin
        data_nxt = right_data;
        occ_nxt  = right_occ;
      end
      dqu_pkg::CELL_PUSH_BACK: begin
        if (is_first_free) begin
          data_nxt = cmd.value;
          occ_nxt  = 1'b1;
        end
      end
      dqu_pkg::CELL_POP_BACK: begin
        if (is_last) begin
          occ_nxt = 1'b0;
        end
      end
      default: begin
        data_nxt = data_r;
        occ_nxt  = occ_r;
      end
    endcase
  end

  // The occupied flag is control state; the value needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o    = data_r;
  assign occ_o     = occ_r;
  assign back_word = is_last ? data_r : '0;

endmodule

// File: src/double_ended_queue_unit.sv
// Top level of the double-ended queue unit: cell chain, control and result register.
// Depends on dqu_pkg and dqu_cell.
`timescale 1ns / 1ps

// A bounded double-ended queue of signed 32-bit values held in a chain of
// DEPTH cells, with the front entry always in the first cell. Every item
// (push back, push front, pop front, pop back) is carried out in the cycle
// of its transfer, and its single result is loaded into an output register
// at the same edge, so the block takes one item per cycle as long as the
// result side keeps up; a pending result blocks input only when it is not
// taken in that cycle. Pushes at the front and pops from the front shift
// every cell by one place toward its neighbor; operations at the back touch
// only the boundary cell. The pop-back value is gathered by an OR over all
// cells, which sets the longest path for large DEPTH. A pop on an empty
// queue and a push on a full queue change nothing and are reported in the
// status. The queue is empty after reset, with no clearing pass.
module double_ended_queue_unit #(
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_action,
  input  logic signed [dqu_pkg::DATA_W-1:0]     in_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [dqu_pkg::DATA_W-1:0]     out_popped_value,
  output logic [1:0]                            out_status,
  output logic [$clog2(DEPTH+1)-1:0]            out_count
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic signed [dqu_pkg::DATA_W-1:0] cell_data [DEPTH];
  logic signed [dqu_pkg::DATA_W-1:0] cell_back [DEPTH];
  logic [DEPTH-1:0]                  cell_occ;
  logic signed [dqu_pkg::DATA_W-1:0] back_value;
  dqu_pkg::cell_cmd_t                cmd;

  logic                              take;
  logic                              full;
  logic                              empty;
  dqu_pkg::action_t                  action;

  logic [CNT_W-1:0]                  count_r, count_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic signed [dqu_pkg::DATA_W-1:0] popped_r, popped_nxt;
  dqu_pkg::status_t                  status_r, status_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;
  assign action   = dqu_pkg::action_t'(in_action);
  assign full     = cell_occ[DEPTH-1];
  assign empty    = !cell_occ[0];

  // The chain of cells; the first cell sees the pushed value as its left
  // neighbor, the last sees an empty cell to its right.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [dqu_pkg::DATA_W-1:0] left_data;
    logic                              left_occ;
    logic signed [dqu_pkg::DATA_W-1:0] right_data;
    logic                              right_occ;

    if (i == 0) begin : g_first
      assign left_data = in_value;
      assign left_occ  = 1'b1;
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
      assign left_occ  = cell_occ[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data = '0;
      assign right_occ  = 1'b0;
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
      assign right_occ  = cell_occ[i+1];
    end

    dqu_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .left_data  (left_data),
      .left_occ   (left_occ),
      .right_data (right_data),
      .right_occ  (right_occ),
      .data_o     (cell_data[i]),
      .occ_o      (cell_occ[i]),
      .back_word  (cell_back[i])
    );
  end

  // Only the last occupied cell drives a nonzero back word.
  always_comb begin
    back_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_value = back_value | cell_back[i];
    end
  end

  // Decode the item into a cell command and the next result.
  always_comb begin
    cmd.op        = dqu_pkg::CELL_HOLD;
    cmd.value     = in_value;
    count_nxt     = count_r;
    popped_nxt    = popped_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (take) begin
      out_valid_nxt = 1'b1;
      popped_nxt    = '0;
      status_nxt    = dqu_pkg::ST_OK;
      case (action)
        dqu_pkg::ACT_PUSH_BACK, dqu_pkg::ACT_PUSH_FRONT: begin
          if (full) begin
            status_nxt = dqu_pkg::ST_FULL;
          end else begin
            cmd.op    = (action == dqu_pkg::ACT_PUSH_BACK) ?
                        dqu_pkg::CELL_PUSH_BACK : dqu_pkg::CELL_PUSH_FRONT;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        dqu_pkg::ACT_POP_FRONT: begin
          if (empty) begin
            status_nxt = dqu_pkg::ST_EMPTY;
          end else begin
            cmd.op     = dqu_pkg::CELL_POP_FRONT;
            popped_nxt = cell_data[0];
            count_nxt  = count_r - CNT_W'(1);
          end
        end
        dqu_pkg::ACT_POP_BACK: begin
          if (empty) begin
            status_nxt = dqu_pkg::ST_EMPTY;
          end else begin
            cmd.op     = dqu_pkg::CELL_POP_BACK;
            popped_nxt = back_value;
            count_nxt  = count_r - CNT_W'(1);
          end
        end
        default: begin
          cmd.op = dqu_pkg::CELL_HOLD;
        end
      endcase
    end
  end

  // Control state: entry count and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register, loaded on each input transfer.
  always_ff @(posedge clk) begin
    popped_r <= popped_nxt;
    status_r <= status_nxt;
  end

  // The count travels with the result; it is the count after the item.
  logic [CNT_W-1:0] res_count_r, res_count_nxt;

  assign res_count_nxt = take ? count_nxt : res_count_r;

  always_ff @(posedge clk) begin
    res_count_r <= res_count_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = popped_r;
  assign out_status       = status_r;
  assign out_count        = res_count_r;

endmodule

// File: sim/double_ended_queue_unit_tb.sv
// Self-checking testbench for double_ended_queue_unit: directed and random deque traffic.
// Depends on dqu_pkg and the RTL of double_ended_queue_unit; needs no other files.
`timescale 1ns / 1ps

module double_ended_queue_unit_tb;

  localparam int DATA_W      = dqu_pkg::DATA_W;
  localparam int DEPTH       = 16;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int ITEM_TARGET = 1550;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 4;

  // One queued request for the driver; hold_off makes it wait for an empty pipe.
  typedef struct {
    dqu_pkg::action_t          act;
    logic signed [DATA_W-1:0]  val;
    bit                        hold_off;
  } deque_request_t;

  // One predicted result.
  typedef struct {
    logic signed [DATA_W-1:0]  popped;
    dqu_pkg::status_t          status;
    logic [CNT_W-1:0]          count;
  } deque_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [1:0]                 in_action = 2'd0;
  logic signed [DATA_W-1:0]   in_value = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [DATA_W-1:0]   out_popped_value;
  logic [1:0]                 out_status;
  logic [CNT_W-1:0]           out_count;

  deque_request_t  pending_requests[$];
  deque_result_t   expected_results[$];
  deque_request_t  next_req;
  deque_result_t   predicted;
  deque_result_t   oldest;

  // Predictor state: ring storage, front index and fill level.
  logic signed [DATA_W-1:0]  ring_mirror[DEPTH];
  int                        mirror_front;
  int                        mirror_fill;

  int  taken_count;
  int  results_seen = 0;
  int  burst_left;
  int  gap_left;
  int  rx_mode;
  int  rx_left;
  int  rx_phase;
  int  cycle_count = 0;
  int  failure_count = 0;
  int  item_total = 0;
  int  push_ok_seen = 0;
  int  pop_ok_seen = 0;
  int  full_seen = 0;
  int  empty_seen = 0;
  int  peak_fill = 0;

  double_ended_queue_unit #(
    .DEPTH(DEPTH)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_popped_value (out_popped_value),
    .out_status       (out_status),
    .out_count        (out_count)
  );

  // Clock generation, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cycle counter that ends a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, expected_results.size());
      $display("double_ended_queue_unit verification failed");
      $finish;
    end
  end

  // Counts a failure and reports the first few in detail.
  task automatic log_failure(input string what);
    failure_count++;
    if (failure_count <= 10) begin
      $display("[%0t] ERROR: %s", $realtime, what);
    end
  endtask

  // Applies one operation to the mirrored deque and returns the result it causes.
  function automatic deque_result_t apply_deque_op(input dqu_pkg::action_t act,
                                                   input logic signed [DATA_W-1:0] val);
    deque_result_t res;
    res.popped = '0;
    res.status = dqu_pkg::ST_OK;
    case (act)
      dqu_pkg::ACT_PUSH_BACK, dqu_pkg::ACT_PUSH_FRONT: begin
        if (mirror_fill >= DEPTH) begin
          res.status = dqu_pkg::ST_FULL;
        end else if (act == dqu_pkg::ACT_PUSH_BACK) begin
          ring_mirror[(mirror_front + mirror_fill) % DEPTH] = val;
          mirror_fill++;
        end else begin
          mirror_front = (mirror_front + DEPTH - 1) % DEPTH;
          ring_mirror[mirror_front] = val;
          mirror_fill++;
        end
      end
      default: begin
        if (mirror_fill == 0) begin
          res.status = dqu_pkg::ST_EMPTY;
        end else if (act == dqu_pkg::ACT_POP_FRONT) begin
          res.popped   = ring_mirror[mirror_front];
          mirror_front = (mirror_front + 1) % DEPTH;
          mirror_fill--;
        end else begin
          res.popped = ring_mirror[(mirror_front + mirror_fill - 1) % DEPTH];
          mirror_fill--;
        end
      end
    endcase
    res.count = mirror_fill[CNT_W-1:0];
    return res;
  endfunction

  // Random push value, weighted toward the extremes and small numbers.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      4:       return $urandom_range(0, 255);
      default: return $urandom();
    endcase
  endfunction

  task automatic add_request(input dqu_pkg::action_t act,
                             input logic signed [DATA_W-1:0] val,
                             input bit hold_off);
    deque_request_t req;
    req.act      = act;
    req.val      = val;
    req.hold_off = hold_off;
    pending_requests.push_back(req);
    item_total++;
  endtask

  // Driver: presents queued requests in bursts with random gaps between them.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid    <= 1'b0;
      taken_count = 0;
      burst_left  = $urandom_range(1, 30);
      gap_left    = 0;
    end else begin
      if (in_valid && in_ready) taken_count++;
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_requests[0].hold_off && taken_count != results_seen) begin
          // Hold off until every expected result has come back.
          in_valid <= 1'b0;
        end else begin
          next_req  = pending_requests.pop_front();
          in_valid  <= 1'b1;
          in_action <= next_req.act;
          in_value  <= next_req.val;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
    end
  end

  // Receiver: stall pattern whose mode is picked anew after each random run.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_mode   = 0;
      rx_left   = 0;
      rx_phase  = 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 150);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 1) == 1);
        2:       out_ready <= (rx_phase % 4 == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Monitor: checks each result transfer, then predicts from each input transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      mirror_front = 0;
      mirror_fill  = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          log_failure($sformatf("result with nothing expected: value %0d status %0d count %0d",
                                out_popped_value, out_status, out_count));
        end else begin
          oldest = expected_results.pop_front();
          if (out_popped_value !== oldest.popped || out_status !== oldest.status ||
              out_count !== oldest.count) begin
            log_failure($sformatf(
              "expected value %0d status %0d count %0d, got value %0d status %0d count %0d",
              oldest.popped, oldest.status, oldest.count,
              out_popped_value, out_status, out_count));
          end
        end
      end
      if (in_valid && in_ready) begin
        predicted = apply_deque_op(dqu_pkg::action_t'(in_action), in_value);
        expected_results.push_back(predicted);
        case (predicted.status)
          dqu_pkg::ST_FULL:  full_seen++;
          dqu_pkg::ST_EMPTY: empty_seen++;
          default: begin
            if (dqu_pkg::action_t'(in_action) inside {dqu_pkg::ACT_PUSH_BACK,
                                                       dqu_pkg::ACT_PUSH_FRONT}) begin
              push_ok_seen++;
            end else begin
              pop_ok_seen++;
            end
          end
        endcase
        if (mirror_fill > peak_fill) peak_fill = mirror_fill;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int push_pct;
    int run_len;
    int k;
    bit hold_next;

    // Directed part: empty pops, extreme values, pointer wrap, fill to full.
    add_request(dqu_pkg::ACT_POP_FRONT, 32'sd5, 1'b0);
    add_request(dqu_pkg::ACT_POP_BACK, -32'sd5, 1'b0);
    add_request(dqu_pkg::ACT_PUSH_BACK, 32'sh7FFF_FFFF, 1'b0);
    add_request(dqu_pkg::ACT_PUSH_FRONT, 32'sh8000_0000, 1'b0);
    add_request(dqu_pkg::ACT_PUSH_BACK, '0, 1'b0);
    add_request(dqu_pkg::ACT_PUSH_FRONT, -32'sd1, 1'b0);
    add_request(dqu_pkg::ACT_POP_BACK, 32'sh1234_5678, 1'b0);
    add_request(dqu_pkg::ACT_POP_FRONT, 32'sh1234_5678, 1'b0);
    for (k = 0; k < DEPTH - 2; k++) begin
      add_request((k % 2 == 0) ? dqu_pkg::ACT_PUSH_BACK : dqu_pkg::ACT_PUSH_FRONT,
                  (k % 3 == 0) ? 32'sh5555_5555 ^ (32'sd1 <<< k) : 32'shAAAA_AAAA >>> k,
                  1'b0);
    end
    add_request(dqu_pkg::ACT_PUSH_BACK, 32'sh0F0F_0F0F, 1'b0);
    add_request(dqu_pkg::ACT_PUSH_FRONT, 32'shF0F0_F0F0, 1'b0);
    add_request(dqu_pkg::ACT_POP_FRONT, '0, 1'b0);

    // Random part: runs biased toward filling or draining, so the queue
    // keeps crossing between empty and full with random content.
    hold_next = 1'b1;
    while (item_total < ITEM_TARGET) begin
      case ($urandom_range(0, 4))
        0:       push_pct = 85;
        1:       push_pct = 65;
        2:       push_pct = 50;
        3:       push_pct = 35;
        default: push_pct = 15;
      endcase
      run_len = $urandom_range(8, 60);
      for (k = 0; k < run_len; k++) begin
        if ($urandom_range(0, 99) < push_pct) begin
          add_request($urandom_range(0, 1) ? dqu_pkg::ACT_PUSH_FRONT : dqu_pkg::ACT_PUSH_BACK,
                      pick_value(), hold_next);
        end else begin
          add_request($urandom_range(0, 1) ? dqu_pkg::ACT_POP_BACK : dqu_pkg::ACT_POP_FRONT,
                      $urandom(), hold_next);
        end
        hold_next = 1'b0;
      end
      if ($urandom_range(0, 7) == 0) hold_next = 1'b1;
    end

    // Release reset.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until all requests are taken and every result has come back.
    @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_WAIT) @(negedge clk);
    if (expected_results.size() != 0) begin
      log_failure($sformatf("%0d expected results never arrived", expected_results.size()));
    end

    $display("Covered %0d transfers: %0d pushes, %0d pops, %0d full rejections, %0d empty pops.",
             item_total, push_ok_seen, pop_ok_seen, full_seen, empty_seen);
    $display("Peak fill level %0d of %0d; %0d failures over %0d cycles.",
             peak_fill, DEPTH, failure_count, cycle_count);
    if (failure_count == 0) begin
      $display("double_ended_queue_unit verification clean");
    end else begin
      $display("double_ended_queue_unit verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/dqu_pkg.sv
src/dqu_cell.sv
src/double_ended_queue_unit.sv
sim/double_ended_queue_unit_tb.sv
